// ----- rtl/ftda_pkg.sv -----
package ftda_pkg;

	// Number format
	localparam int VALUE_W      = 32;
	localparam int FRAC_BITS    = 16;
	localparam int IPART_W      = VALUE_W - FRAC_BITS;
	localparam int MAX_DECIMALS = 9;
	localparam int DEC_W        = 4;
	localparam logic [DEC_W-1:0] DECIMALS_RESET = 4'd2;

	// Decimal digits needed for an unsigned value of the given width
	function automatic int digits_for(input int bits);
		longint v;
		int n;
		v = (longint'(1) <<< bits) - 1;
		n = 0;
		do begin
			v = v / 10;
			n++;
		end while (v != 0);
		return n;
	endfunction

	localparam int NDIG   = digits_for(IPART_W);
	localparam int BCD_W  = NDIG * 4;
	localparam int DIG_IW = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int CNT_W  = $clog2(IPART_W + 1);
	localparam int FW10   = FRAC_BITS + 4;

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Shared unit operations
	typedef enum logic [1:0] {
		OP_DABBLE  = 2'b01,
		OP_TIMES10 = 2'b10
	} ftda_op_t;

	// Shared unit results
	typedef struct packed {
		logic [BCD_W-1:0]     bcd;
		logic [IPART_W-1:0]   bin;
		logic [FRAC_BITS-1:0] frac;
		logic [3:0]           digit;
	} ftda_unit_res_t;

endpackage

// ----- rtl/ftda_ifs.sv -----
interface ftda_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [ftda_pkg::VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface ftda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

interface ftda_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ftda_pkg::DEC_W-1:0]     decimals;
	modport source (output valid, output decimals, input ready);
	modport sink   (input valid, input decimals, output ready);
endinterface

// ----- rtl/fixed_to_decimal_ascii.sv -----
// Channel  Role    Transfer when        Payload
// din      sink    valid && ready       value (signed Q15.16)
// dout     source  valid && ready       character, last (set on NUL)
// cfg      sink    valid && ready       decimals (ready always high)
//
// A value is accepted, converted to BCD over its IPART_W integer bits in the
// shared shift/add unit, then sent one character per cycle (up to 17) while
// dout is ready.
// Fraction digits reuse the same unit as a multiply-by-ten step.
// arst_n clears the sequencer, the output valid and sets decimals to 2.
// A dout stall holds the sequencer in its character states; din is ready only between values.
module fixed_to_decimal_ascii (
	input  logic              clk,
	input  logic              arst_n,
	ftda_in_if.sink           din,
	ftda_out_if.source        dout,
	ftda_cfg_if.sink          cfg
);
	import ftda_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CONV  = 7'b0000010,
		S_SIGN  = 7'b0000100,
		S_INT   = 7'b0001000,
		S_POINT = 7'b0010000,
		S_FRAC  = 7'b0100000,
		S_TERM  = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [DEC_W-1:0]     dec_q;
	logic                 neg_q;
	logic [IPART_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIG_IW-1:0]    dig_q;
	logic [DEC_W-1:0]     fcnt_q;
	logic                 ov_q;
	logic [7:0]           och_q;
	logic                 olast_q;

	logic [VALUE_W-1:0]   raw;
	logic [VALUE_W-1:0]   mag;
	logic [DEC_W-1:0]     nd;
	logic [DIG_IW-1:0]    lead;
	logic                 emit_ok;
	logic                 emit;
	logic [7:0]           ch;
	logic                 ch_last;
	ftda_op_t             op;
	ftda_unit_res_t       res;

	// Configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= DECIMALS_RESET;
		end else if (cfg.valid) begin
			dec_q <= cfg.decimals;
		end
	end

	// Saturated digit count
	assign nd = (dec_q > DEC_W'(MAX_DECIMALS)) ? DEC_W'(MAX_DECIMALS) : dec_q;

	// Magnitude of the input
	assign raw = din.value;
	assign mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

	// Shared shift/add unit
	assign op = (state_q == S_FRAC) ? OP_TIMES10 : OP_DABBLE;

	ftda_unit u_unit (
		.op   (op),
		.bcd  (bcd_q),
		.bin  (bin_q),
		.frac (frac_q),
		.res  (res)
	);

	// Highest nonzero BCD digit of the finished conversion
	always_comb begin
		lead = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (res.bcd[i*4 +: 4] != 4'd0) begin
				lead = DIG_IW'(i);
			end
		end
	end

	assign din.ready = (state_q == S_IDLE);
	assign emit_ok   = !ov_q || dout.ready;

	// Character chosen by the current state
	always_comb begin
		emit = 1'b0;
		ch = CH_NUL;
		ch_last = 1'b0;
		case (state_q)
			S_SIGN: begin
				emit = 1'b1;
				ch = CH_MINUS;
			end
			S_INT: begin
				emit = 1'b1;
				ch = CH_ZERO + {4'b0, bcd_q[dig_q*4 +: 4]};
			end
			S_POINT: begin
				emit = 1'b1;
				ch = CH_POINT;
			end
			S_FRAC: begin
				emit = 1'b1;
				ch = CH_ZERO + {4'b0, res.digit};
			end
			S_TERM: begin
				emit = 1'b1;
				ch = CH_NUL;
				ch_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (din.valid) state_q <= S_CONV;
				end
				S_CONV: begin
					if (cnt_q == CNT_W'(1)) state_q <= neg_q ? S_SIGN : S_INT;
				end
				S_SIGN: begin
					if (emit_ok) state_q <= S_INT;
				end
				S_INT: begin
					if (emit_ok && dig_q == '0) state_q <= S_POINT;
				end
				S_POINT: begin
					if (emit_ok) state_q <= (nd == '0) ? S_TERM : S_FRAC;
				end
				S_FRAC: begin
					if (emit_ok && fcnt_q == DEC_W'(1)) state_q <= S_TERM;
				end
				S_TERM: begin
					if (emit_ok) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				neg_q  <= raw[VALUE_W-1];
				bin_q  <= mag[VALUE_W-1:FRAC_BITS];
				frac_q <= mag[FRAC_BITS-1:0];
				bcd_q  <= '0;
				cnt_q  <= CNT_W'(IPART_W);
			end
			S_CONV: begin
				bcd_q <= res.bcd;
				bin_q <= res.bin;
				cnt_q <= cnt_q - CNT_W'(1);
				dig_q <= lead;
			end
			S_INT: begin
				if (emit_ok && dig_q != '0) dig_q <= dig_q - DIG_IW'(1);
			end
			S_POINT: begin
				fcnt_q <= nd;
			end
			S_FRAC: begin
				if (emit_ok) begin
					frac_q <= res.frac;
					fcnt_q <= fcnt_q - DEC_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit && emit_ok) begin
			ov_q <= 1'b1;
		end else if (dout.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && emit_ok) begin
			och_q   <= ch;
			olast_q <= ch_last;
		end
	end

	assign dout.valid     = ov_q;
	assign dout.character = och_q;
	assign dout.last      = olast_q;

	// Checks
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> state_q == S_CONV)
		else $error("accepted value did not start conversion");

	a_last_nul: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.last |-> dout.character == CH_NUL)
		else $error("last flag on a non-terminator");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !din.ready)
		else $error("input ready while busy");

	a_frac_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAC |-> fcnt_q != '0)
		else $error("fraction digit count underflow");

endmodule

// ----- rtl/ftda_unit.sv -----
module ftda_unit (
	input  ftda_pkg::ftda_op_t               op,
	input  logic [ftda_pkg::BCD_W-1:0]       bcd,
	input  logic [ftda_pkg::IPART_W-1:0]     bin,
	input  logic [ftda_pkg::FRAC_BITS-1:0]   frac,
	output ftda_pkg::ftda_unit_res_t         res
);
	import ftda_pkg::*;

	logic [BCD_W-1:0] adj;
	logic [FW10-1:0]  prod;

	// Double-dabble: add 3 to every BCD digit of 5 or more
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd[i*4 +: 4];
			end
		end
	end

	// frac * 10 as (frac << 3) + (frac << 1)
	assign prod = ({4'b0, frac} << 3) + ({4'b0, frac} << 1);

	always_comb begin
		res = '0;
		case (op)
			OP_DABBLE: begin
				res.bcd = {adj[BCD_W-2:0], bin[IPART_W-1]};
				res.bin = bin << 1;
				res.frac = frac;
			end
			OP_TIMES10: begin
				res.bcd = bcd;
				res.bin = bin;
				res.frac = prod[FRAC_BITS-1:0];
				res.digit = prod[FW10-1:FRAC_BITS];
			end
			default: begin
				res.bcd = bcd;
				res.bin = bin;
				res.frac = frac;
			end
		endcase
	end

endmodule
